// ----- src/tcf_pkg.sv -----
// Package for the tilt complementary filter: sequencer states, fixed-point
// widths and the CORDIC arctangent table. No dependencies.
package tcf_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int TABLE_LEN    = 24;
    localparam int CORDIC_ITERS = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;
    localparam int CW           = 28;   // CORDIC x/y width
    localparam int ZW           = 30;   // angle width, LSB 2^-20 degree
    localparam int ANGLE_LIMIT  = 23040;
    localparam logic [ZW-1:0] DEG90 = ZW'(94371840);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RLOAD,
        ST_RITER,
        ST_SQ_A,
        ST_SQ_B,
        ST_SQRT,
        ST_PLOAD,
        ST_PITER,
        ST_BL_A,
        ST_BL_B,
        ST_BL_C,
        ST_BL_D,
        ST_DONE
    } t_state;

    localparam logic [7:0] REG_ACCEL_WEIGHT  = 8'd0;
    localparam logic [7:0] REG_SAMPLE_PERIOD = 8'd1;

    // atan(2^-i) in degrees * 2^20, rounded to nearest
    function automatic logic [26:0] atan_entry(input logic [4:0] idx);
        logic [26:0] v;
        case (idx)
            5'd0:  v = 27'd47185920;
            5'd1:  v = 27'd27855475;
            5'd2:  v = 27'd14718068;
            5'd3:  v = 27'd7471121;
            5'd4:  v = 27'd3750058;
            5'd5:  v = 27'd1876857;
            5'd6:  v = 27'd938658;
            5'd7:  v = 27'd469357;
            5'd8:  v = 27'd234682;
            5'd9:  v = 27'd117342;
            5'd10: v = 27'd58671;
            5'd11: v = 27'd29335;
            5'd12: v = 27'd14668;
            5'd13: v = 27'd7334;
            5'd14: v = 27'd3667;
            5'd15: v = 27'd1833;
            5'd16: v = 27'd917;
            5'd17: v = 27'd458;
            5'd18: v = 27'd229;
            5'd19: v = 27'd115;
            5'd20: v = 27'd57;
            5'd21: v = 27'd29;
            5'd22: v = 27'd14;
            5'd23: v = 27'd7;
            default: v = 27'd0;
        endcase
        return v;
    endfunction

endpackage

// ----- src/tilt_complementary_filter_unit.sv -----
// Tilt complementary filter top level: CORDIC tilt angles, square root and
// gyro/accelerometer blend under one sequencer. Depends on tcf_pkg.

// One request carries an IMU sample; the block answers with one roll/pitch
// pair (LSB 1/128 degree, saturated at +/-180). A sample passes through a
// load state and CORDIC_STEPS iterations of one shared vectoring CORDIC
// for roll, forming ay^2 + az^2 and 16 steps of a bit-serial square root,
// a load state and CORDIC_STEPS iterations again for pitch, two blend
// passes (roll, then pitch), the hand-over of the result and an idle state
// that takes the next request.
// s_axis_tready is high only while the sequencer is idle; a finished result
// sits in the output register so the next sample can be taken while it waits.
module tilt_complementary_filter_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata: accel_x, accel_y, accel_z, rate_roll, rate_pitch (16 bits each)
    input  logic [79:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata: roll_out, pitch_out (16 bits each)
    output logic [31:0] m_axis_tdata
);
    import tcf_pkg::*;

    t_state r_state, n_state;

    // configuration
    logic [15:0] r_weight, r_period;

    // latched sample
    logic signed [15:0] r_ax, r_ay, r_az, r_gr, r_gp;

    // filter state
    logic signed [15:0] r_roll_angle, r_pitch_angle;

    // CORDIC datapath
    logic signed [CW-1:0] r_cx, r_cy;
    logic signed [ZW-1:0] r_cz, r_roll_a;
    logic                 r_zero;
    logic [4:0]           r_cnt;

    // square root
    logic [31:0] r_rem, r_res;

    // blend
    logic               r_sel;      // 0: roll, 1: pitch
    logic signed [33:0] r_sum;
    logic signed [51:0] r_prod;
    logic signed [52:0] r_blend;

    // output register
    logic        r_out_valid;
    logic [31:0] r_out_data;

    logic cordic_last, sqrt_last;
    assign cordic_last = (r_cnt == 5'(CORDIC_ITERS - 1));
    assign sqrt_last   = (r_cnt == 5'd15);

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:  if (s_axis_tvalid) n_state = ST_RLOAD;
            ST_RLOAD: n_state = ST_RITER;
            ST_RITER: if (cordic_last) n_state = ST_SQ_A;
            ST_SQ_A:  n_state = ST_SQ_B;
            ST_SQ_B:  n_state = ST_SQRT;
            ST_SQRT:  if (sqrt_last) n_state = ST_PLOAD;
            ST_PLOAD: n_state = ST_PITER;
            ST_PITER: if (cordic_last) n_state = ST_BL_A;
            ST_BL_A:  n_state = ST_BL_B;
            ST_BL_B:  n_state = ST_BL_C;
            ST_BL_C:  n_state = ST_BL_D;
            ST_BL_D:  n_state = r_sel ? ST_DONE : ST_BL_A;
            ST_DONE:  if (!r_out_valid || m_axis_tready) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_IDLE;
        else          r_state <= n_state;
    end

    // CORDIC load operands: roll uses (y=ay, x=az), pitch uses (y=-ax, x=mag)
    logic signed [CW-1:0] ld_x, ld_y;
    always_comb begin
        if (r_state == ST_RLOAD) begin
            ld_x = CW'(r_az) <<< 8;
            ld_y = CW'(r_ay) <<< 8;
        end else begin
            ld_x = $signed(CW'(r_res[15:0])) <<< 8;
            ld_y = -(CW'(r_ax) <<< 8);
        end
    end

    // one CORDIC micro-rotation
    logic signed [CW-1:0] xs, ys;
    logic signed [ZW-1:0] tab;
    assign xs  = r_cx >>> r_cnt;
    assign ys  = r_cy >>> r_cnt;
    assign tab = $signed(ZW'(atan_entry(r_cnt)));

    // one square-root digit
    logic [4:0]  sq_shift;
    logic [31:0] sq_bit;
    logic [32:0] sq_trial;
    assign sq_shift = 5'd30 - {r_cnt[3:0], 1'b0};
    assign sq_bit   = 32'd1 << sq_shift;
    assign sq_trial = {1'b0, r_res} + {1'b0, sq_bit};

    // blend operands for the angle in progress
    logic signed [15:0]   bl_rate, bl_prev;
    logic signed [ZW-1:0] bl_accel;
    logic signed [17:0]   bl_wc;
    logic signed [23:0]   bl_round;
    logic signed [15:0]   bl_sat;
    assign bl_rate  = r_sel ? r_gp : r_gr;
    assign bl_prev  = r_sel ? r_pitch_angle : r_roll_angle;
    assign bl_accel = r_sel ? r_cz : r_roll_a;
    assign bl_wc    = 18'sd65536 - $signed({2'b00, r_weight});
    assign bl_round = 24'((r_blend + 53'sd268435456) >>> 29);
    always_comb begin
        if (bl_round > 24'sd23040)       bl_sat = 16'(ANGLE_LIMIT);
        else if (bl_round < -24'sd23040) bl_sat = -16'(ANGLE_LIMIT);
        else                             bl_sat = bl_round[15:0];
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_weight      <= 16'd45875;
            r_period      <= 16'd655;
            r_roll_angle  <= '0;
            r_pitch_angle <= '0;
            r_out_valid   <= 1'b0;
            r_cnt         <= '0;
            r_sel         <= 1'b0;
        end else begin
            if (i_cfg_we && i_cfg_idx == REG_ACCEL_WEIGHT)  r_weight <= i_cfg_data;
            if (i_cfg_we && i_cfg_idx == REG_SAMPLE_PERIOD) r_period <= i_cfg_data;
            // load a finished result, else drop the one just taken
            if (r_state == ST_DONE && (!r_out_valid || m_axis_tready))
                r_out_valid <= 1'b1;
            else if (r_out_valid && m_axis_tready)
                r_out_valid <= 1'b0;
            case (r_state)
                ST_RLOAD, ST_PLOAD, ST_SQ_B: r_cnt <= '0;
                ST_RITER, ST_PITER, ST_SQRT: r_cnt <= r_cnt + 5'd1;
                ST_BL_D: begin
                    if (r_sel) r_pitch_angle <= bl_sat;
                    else       r_roll_angle  <= bl_sat;
                    r_sel <= ~r_sel;
                end
                default: ;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_ax <= s_axis_tdata[15:0];
                r_ay <= s_axis_tdata[31:16];
                r_az <= s_axis_tdata[47:32];
                r_gr <= s_axis_tdata[63:48];
                r_gp <= s_axis_tdata[79:64];
            end
            ST_RLOAD, ST_PLOAD: begin
                // pre-rotate by 90 degrees when x is negative
                r_zero <= (ld_x == 0) && (ld_y == 0);
                if (ld_x < 0) begin
                    if (ld_y >= 0) begin
                        r_cx <= ld_y;  r_cy <= -ld_x; r_cz <= DEG90;
                    end else begin
                        r_cx <= -ld_y; r_cy <= ld_x;  r_cz <= -DEG90;
                    end
                end else begin
                    r_cx <= ld_x; r_cy <= ld_y; r_cz <= '0;
                end
            end
            ST_RITER, ST_PITER: begin
                if (r_cy > 0) begin
                    r_cx <= r_cx + ys; r_cy <= r_cy - xs;
                end else begin
                    r_cx <= r_cx - ys; r_cy <= r_cy + xs;
                end
                // a zero vector ends at angle zero
                if (cordic_last && r_zero) r_cz <= '0;
                else if (r_cy > 0)         r_cz <= r_cz + tab;
                else                       r_cz <= r_cz - tab;
                if (r_state == ST_RITER && cordic_last) begin
                    r_roll_a <= r_zero ? '0 :
                                ((r_cy > 0) ? r_cz + tab : r_cz - tab);
                end
            end
            ST_SQ_A: begin
                r_rem <= 32'(r_ay * r_ay);
                r_res <= '0;
            end
            ST_SQ_B: r_rem <= r_rem + 32'(r_az * r_az);
            ST_SQRT: begin
                if ({1'b0, r_rem} >= sq_trial) begin
                    r_rem <= r_rem - sq_trial[31:0];
                    r_res <= (r_res >> 1) + sq_bit;
                end else begin
                    r_res <= r_res >> 1;
                end
            end
            ST_BL_A: r_sum  <= 34'(bl_rate * $signed({1'b0, r_period}))
                               + (34'(bl_prev) <<< 13);
            ST_BL_B: r_prod <= 52'(r_sum * bl_wc);
            ST_BL_C: r_blend <= 53'(r_prod)
                                + 53'(bl_accel * $signed({1'b0, r_weight}));
            ST_DONE: if (!r_out_valid || m_axis_tready)
                r_out_data <= {r_pitch_angle, r_roll_angle};
            default: ;
        endcase
    end

endmodule
